[rtl/nearest_point_search_defines.svh]
// Assertion macros for the checker module npsrch_chk.
`ifndef NEAREST_POINT_SEARCH_DEFINES_SVH
`define NEAREST_POINT_SEARCH_DEFINES_SVH

// Checked only while reset is released.
`define NPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define NPS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/npsrch_pkg.sv]
package npsrch_pkg;

  localparam int Rows      = 2;
  localparam int Cols      = 16;
  localparam int Slots     = Rows * Cols;
  localparam int SlotW     = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int RowW      = 1;
  localparam int ColW      = 4;
  localparam int CoordW    = 28;
  localparam int DistW     = 28;
  localparam int DiffW     = 28;
  localparam int SqW       = 2 * DiffW + 1;
  localparam int RootW     = (SqW + 1) / 2;
  localparam int RemW      = RootW + 3;
  localparam int DrainW    = 2;
  localparam int DrainLast = 2;

  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StFinish,
    StSqrt,
    StOut
  } state_e;

  typedef struct packed {
    logic             load_wr;
    logic             query_start;
    logic             issue;
    logic [SlotW-1:0] addr;
    logic             sqrt_start;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic sqrt_done;
    logic out_free;
  } status_t;

endpackage

[rtl/npsrch_isqrt.sv]
module npsrch_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [npsrch_pkg::SqW-1:0]    operand_i,
  output logic                          done_o,
  output logic [npsrch_pkg::RootW-1:0]  root_o
);
  import npsrch_pkg::*;

  localparam int CntW = $clog2(RootW);

  logic                 run_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q;
  logic [2*RootW-1:0]   opnd_q;
  logic [RemW-1:0]      rem_q;
  logic [RootW-1:0]     root_q;
  logic [RemW-1:0]      rem_sh;
  logic [RemW-1:0]      trial;
  logic                 take;

  always_comb begin
    rem_sh = {rem_q[RemW-3:0], opnd_q[2*RootW-1 -: 2]};
    trial  = RemW'({root_q, 2'b01});
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(RootW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opnd_q <= (2*RootW)'(operand_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      opnd_q <= {opnd_q[2*RootW-3:0], 2'b00};
      if (take) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[rtl/npsrch_ctrl.sv]
module npsrch_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 req_type_i,
  output logic                 in_stall_o,
  output npsrch_pkg::cmd_t     cmd_o,
  input  npsrch_pkg::status_t  status_i
);
  import npsrch_pkg::*;

  state_e            state_q, state_d;
  logic [SlotW-1:0]  addr_q;
  logic [DrainW-1:0] drain_q;
  logic              scan_last;
  logic              drain_last;

  assign scan_last  = (addr_q == SlotW'(Slots - 1));
  assign drain_last = (drain_q == DrainW'(DrainLast));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && (req_type_i == ReqQuery)) state_d = StScan;
      end
      StScan: begin
        if (scan_last) state_d = StDrain;
      end
      StDrain: begin
        if (drain_last) state_d = StFinish;
      end
      StFinish: begin
        state_d = status_i.found ? StSqrt : StOut;
      end
      StSqrt: begin
        if (status_i.sqrt_done) state_d = StOut;
      end
      StOut: begin
        if (status_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o        = (state_q != StIdle);
    cmd_o             = '0;
    cmd_o.addr        = addr_q;
    unique case (state_q)
      StIdle: begin
        cmd_o.load_wr     = in_valid_i && (req_type_i == ReqLoad);
        cmd_o.query_start = in_valid_i && (req_type_i == ReqQuery);
      end
      StScan:   cmd_o.issue      = 1'b1;
      StFinish: cmd_o.sqrt_start = status_i.found;
      StOut:    cmd_o.out_load   = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      addr_q  <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_o.query_start) begin
        addr_q <= '0;
      end else if (state_q == StScan && !scan_last) begin
        addr_q <= addr_q + 1'b1;
      end
      if (state_q == StScan) begin
        drain_q <= '0;
      end else if (state_q == StDrain) begin
        drain_q <= drain_q + 1'b1;
      end
    end
  end

endmodule

[rtl/npsrch_dp.sv]
module npsrch_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [npsrch_pkg::RowW-1:0]        entry_row_i,
  input  logic [npsrch_pkg::ColW-1:0]        entry_col_i,
  input  logic signed [npsrch_pkg::CoordW-1:0] point_lat_i,
  input  logic [npsrch_pkg::CoordW-1:0]      point_lon_i,
  input  npsrch_pkg::cmd_t                   cmd_i,
  output npsrch_pkg::status_t                status_o,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic                               found_o,
  output logic [npsrch_pkg::RowW-1:0]        spot_row_o,
  output logic [npsrch_pkg::ColW-1:0]        spot_col_o,
  output logic [npsrch_pkg::DistW-1:0]       distance_o
);
  import npsrch_pkg::*;

  logic [2*CoordW-1:0] mem_q [Slots];
  logic [2*CoordW-1:0] rd_q;
  logic [Slots-1:0]    valid_q;
  logic                key_ok;
  logic [SlotW-1:0]    wr_idx;

  logic [CoordW-1:0]   qlat_q;
  logic [CoordW-1:0]   qlon_q;

  logic                s1_v_q, s2_v_q, s3_v_q;
  logic [SlotW-1:0]    s1_slot_q, s2_slot_q, s3_slot_q;
  logic [CoordW:0]     dlat, dlon;
  logic [DiffW-1:0]    s2_dl_q, s2_dn_q;
  logic [2*DiffW-1:0]  s3_sql_q, s3_sqn_q;
  logic [SqW-1:0]      sum;

  logic                found_q;
  logic [SqW-1:0]      best_sq_q;
  logic [SlotW-1:0]    best_slot_q;

  logic                sqrt_done;
  logic [RootW-1:0]    root;
  logic [DistW-1:0]    last_dist_q;

  logic                out_valid_q;
  logic                out_found_q;
  logic [RowW-1:0]     out_row_q;
  logic [ColW-1:0]     out_col_q;
  logic [DistW-1:0]    out_dist_q;

  assign key_ok = (int'(entry_row_i) < Rows) && (int'(entry_col_i) < Cols);
  assign wr_idx = SlotW'(int'(entry_row_i) * Cols + int'(entry_col_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && key_ok) begin
      mem_q[wr_idx] <= {point_lat_i, point_lon_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_q <= mem_q[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.load_wr && key_ok) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      qlat_q <= point_lat_i;
      qlon_q <= point_lon_i;
    end
  end

  always_comb begin
    dlat = {qlat_q[CoordW-1], qlat_q} - {rd_q[2*CoordW-1], rd_q[2*CoordW-1:CoordW]};
    dlon = {1'b0, qlon_q} - {1'b0, rd_q[CoordW-1:0]};
    sum  = SqW'(s3_sql_q) + SqW'(s3_sqn_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.issue && valid_q[cmd_i.addr];
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_slot_q <= cmd_i.addr;
    s2_slot_q <= s1_slot_q;
    s3_slot_q <= s2_slot_q;
    s2_dl_q   <= dlat[CoordW] ? DiffW'(-dlat) : DiffW'(dlat);
    s2_dn_q   <= dlon[CoordW] ? DiffW'(-dlon) : DiffW'(dlon);
    s3_sql_q  <= (2*DiffW)'(s2_dl_q) * (2*DiffW)'(s2_dl_q);
    s3_sqn_q  <= (2*DiffW)'(s2_dn_q) * (2*DiffW)'(s2_dn_q);
  end

  // The first valid candidate is taken as found; a later one replaces it only when strictly smaller.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      best_slot_q <= '0;
    end else if (cmd_i.query_start) begin
      found_q     <= 1'b0;
      best_slot_q <= '0;
    end else if (s3_v_q && (!found_q || sum < best_sq_q)) begin
      found_q     <= 1'b1;
      best_slot_q <= s3_slot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_v_q && (!found_q || sum < best_sq_q)) begin
      best_sq_q <= sum;
    end
  end

  npsrch_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.sqrt_start),
    .operand_i (best_sq_q),
    .done_o    (sqrt_done),
    .root_o    (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_dist_q <= '0;
    end else if (sqrt_done) begin
      last_dist_q <= (root[RootW-1:DistW] != '0) ? '1 : root[DistW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_found_q <= found_q;
      out_row_q   <= RowW'(int'(best_slot_q) / Cols);
      out_col_q   <= ColW'(int'(best_slot_q) % Cols);
      out_dist_q  <= last_dist_q;
    end
  end

  assign status_o.found     = found_q;
  assign status_o.sqrt_done = sqrt_done;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign spot_row_o  = out_row_q;
  assign spot_col_o  = out_col_q;
  assign distance_o  = out_dist_q;

endmodule

[rtl/nearest_point_search.sv]
// Nearest reference point search over a table of Rows x Cols slots.
// Input channel (in_valid_i / in_stall_o) carries one word per request.
// A load word (req_type_i = 0) writes the latitude and longitude of one
// slot and marks it valid; it is taken without a stall and gives no result.
// A query word (req_type_i = 1) scans all slots in key order, row first,
// then column, and gives one result word on the output channel
// (out_valid_o / out_stall_i): found flag, winning key and distance.
// A query with no valid slot skips the square root unit; otherwise the
// best squared distance passes through that unit first; the slot scan
// reads one table entry per cycle through a four-stage distance pipeline,
// and the square root unit retires one result bit per cycle.
// The input stalls while a query is in progress; a result waiting in the
// output register does not block the next load or query from entering.
// When the receiver stalls, the result word holds until it is taken.
// Reset clears all valid marks and the last distance, so the table is
// empty and an early query reports key zero with distance zero.
module nearest_point_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [npsrch_pkg::RowW-1:0]          entry_row_i,
  input  logic [npsrch_pkg::ColW-1:0]          entry_col_i,
  input  logic signed [npsrch_pkg::CoordW-1:0] point_lat_i,
  input  logic [npsrch_pkg::CoordW-1:0]        point_lon_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 found_o,
  output logic [npsrch_pkg::RowW-1:0]          spot_row_o,
  output logic [npsrch_pkg::ColW-1:0]          spot_col_o,
  output logic [npsrch_pkg::DistW-1:0]         distance_o
);
  import npsrch_pkg::*;

  cmd_t    cmd;
  status_t status;

  npsrch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  npsrch_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_row_i (entry_row_i),
    .entry_col_i (entry_col_i),
    .point_lat_i (point_lat_i),
    .point_lon_i (point_lon_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .found_o     (found_o),
    .spot_row_o  (spot_row_o),
    .spot_col_o  (spot_col_o),
    .distance_o  (distance_o)
  );

endmodule

[rtl/npsrch_chk.sv]
`include "nearest_point_search_defines.svh"

module npsrch_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 req_type_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic                                 found_o,
  input logic [npsrch_pkg::RowW-1:0]          spot_row_o,
  input logic [npsrch_pkg::ColW-1:0]          spot_col_o,
  input logic [npsrch_pkg::DistW-1:0]         distance_o
);

  `NPS_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |-> !out_valid_o, "result word shown in reset")

  `NPS_ASSERT(a_result_held, out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) && $stable(spot_row_o) && $stable(spot_col_o) && $stable(distance_o), "stalled result word changed")

  `NPS_ASSERT(a_miss_key_zero, out_valid_o && !found_o |-> spot_row_o == '0 && spot_col_o == '0, "empty search reported a nonzero key")

  `NPS_ASSERT(a_query_busy, in_valid_i && !in_stall_o && req_type_i |=> in_stall_o, "query word did not start a scan")

  `NPS_ASSERT(a_load_one_cycle, in_valid_i && !in_stall_o && !req_type_i |=> !in_stall_o, "load word held off the input")

endmodule

bind nearest_point_search npsrch_chk u_npsrch_chk (.*);
